FILE: rtl/mm4_pkg.sv
package mm4_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
  localparam logic        CMD_LOAD  = 1'b0;
  localparam logic        CMD_MUL   = 1'b1;
  localparam int          NUM_ROWS  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RAW,
    ST_MUL_RND,
    ST_ADD_RAW,
    ST_ADD_RND,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_col;
    logic       mul_raw;
    logic       mul_rnd;
    logic       add_raw;
    logic       add_rnd;
    logic [1:0] k;
  } lane_ctrl_t;

  // unrounded operation result, or a finished special value
  typedef struct packed {
    logic               special;
    logic [31:0]        bits;
    logic               sign;
    logic signed [11:0] exp;
    logic [63:0]        sig;
  } fp_raw_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > INF_MAG;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:0] == INF_MAG;
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] unp_sig(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic logic signed [11:0] unp_exp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, x[30:23]}) - 12'sd150;
  endfunction

  function automatic fp_raw_t fp_mul_raw(input logic [31:0] a, input logic [31:0] b);
    fp_raw_t     r;
    logic        s;
    logic [47:0] prod;
    r = '0;
    s = a[31] ^ b[31];
    r.sign = s;
    prod = unp_sig(a) * unp_sig(b);
    priority if (is_nan(a) || is_nan(b)) begin
      r.special = 1'b1;
      r.bits = QNAN_BITS;
    end else if (is_inf(a) || is_inf(b)) begin
      r.special = 1'b1;
      r.bits = (is_zero(a) || is_zero(b)) ? QNAN_BITS : {s, INF_MAG};
    end else if (is_zero(a) || is_zero(b)) begin
      r.special = 1'b1;
      r.bits = {s, 31'd0};
    end else begin
      r.exp = unp_exp(a) + unp_exp(b);
      r.sig = {16'd0, prod};
    end
    return r;
  endfunction

  function automatic fp_raw_t fp_add_raw(input logic [31:0] a, input logic [31:0] b);
    fp_raw_t            r;
    logic               sa_s, sb_s, ts;
    logic [23:0]        ma, mb, tm;
    logic signed [11:0] ea, eb, te, d, rr;
    logic [63:0]        x, y;
    logic signed [11:0] ebase;
    r = '0;
    sa_s = a[31];
    sb_s = b[31];
    ma = unp_sig(a);
    mb = unp_sig(b);
    ea = unp_exp(a);
    eb = unp_exp(b);
    if (ea < eb || (ea == eb && ma < mb)) begin
      ts = sa_s; sa_s = sb_s; sb_s = ts;
      tm = ma; ma = mb; mb = tm;
      te = ea; ea = eb; eb = te;
    end
    d = ea - eb;
    rr = d - 12'sd38;
    if (d <= 12'sd38) begin
      x = 64'(ma) << d[5:0];
      y = 64'(mb);
      ebase = eb;
    end else begin
      x = 64'(ma) << 38;
      ebase = ea - 12'sd38;
      if (rr >= 12'sd24) y = 64'd1;
      else y = (64'(mb) >> rr[4:0])
             | 64'((64'(mb) & ((64'd1 << rr[4:0]) - 64'd1)) != 64'd0);
    end
    r.sign = sa_s;
    r.exp = ebase;
    priority if (is_nan(a) || is_nan(b)) begin
      r.special = 1'b1;
      r.bits = QNAN_BITS;
    end else if (is_inf(a) || is_inf(b)) begin
      r.special = 1'b1;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) r.bits = QNAN_BITS;
      else r.bits = is_inf(a) ? a : b;
    end else if (is_zero(a) && is_zero(b)) begin
      r.special = 1'b1;
      r.bits = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      r.special = 1'b1;
      r.bits = b;
    end else if (is_zero(b)) begin
      r.special = 1'b1;
      r.bits = a;
    end else if (sa_s == sb_s) begin
      r.sig = x + y;
    end else if (x == y) begin
      r.special = 1'b1;
      r.bits = 32'd0;
    end else begin
      r.sig = x - y;
    end
    return r;
  endfunction

  // round sign * sig * 2^e to single, nearest even
  function automatic logic [31:0] fp_round(input fp_raw_t r);
    logic [5:0]         p;
    logic signed [12:0] sh, lim, e2, bexp;
    logic [63:0]        m, rem, half;
    logic [31:0]        res;
    if (r.special) return r.bits;
    p = '0;
    for (int i = 0; i < 64; i++) if (r.sig[i]) p = 6'(i);
    sh = $signed({7'd0, p}) - 13'sd23;
    lim = -13'sd149 - 13'(r.exp);
    if (lim > sh) sh = lim;
    rem = '0;
    half = '0;
    if (sh <= 13'sd0) begin
      m = r.sig << 6'(-sh);
    end else if (sh >= 13'sd64) begin
      m = '0;
    end else begin
      m = r.sig >> sh[5:0];
      rem = r.sig & ((64'd1 << sh[5:0]) - 64'd1);
      half = 64'd1 << (sh[5:0] - 6'd1);
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    e2 = 13'(r.exp) + sh;
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      e2 = e2 + 13'sd1;
    end
    bexp = e2 + 13'sd150;
    if (m < (64'd1 << 23)) res = {r.sign, 8'd0, m[22:0]};
    else if (bexp >= 13'sd255) res = {r.sign, INF_MAG};
    else res = {r.sign, bexp[7:0], m[22:0]};
    return res;
  endfunction

endpackage

FILE: rtl/mm4_lane.sv
module mm4_lane
  import mm4_pkg::*;
(
  input  logic        clk,
  input  lane_ctrl_t  ctrl,
  input  logic [31:0] wr_data,
  input  logic [31:0] b_elem,
  output logic [31:0] acc
);

  // this lane's row of the left matrix, one word per column
  logic [31:0] row_store [4];
  logic [31:0] prod;
  fp_raw_t     raw;
  logic [31:0] rounded;

  always_comb begin
    rounded = fp_round(raw);
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      row_store[ctrl.wr_col] <= wr_data;
    end
    if (ctrl.mul_raw) begin
      raw <= fp_mul_raw(row_store[ctrl.k], b_elem);
    end else if (ctrl.add_raw) begin
      raw <= fp_add_raw(acc, prod);
    end
    if (ctrl.mul_rnd) begin
      if (ctrl.k == 2'd0) acc <= rounded;
      else prod <= rounded;
    end else if (ctrl.add_rnd) begin
      acc <= rounded;
    end
  end

endmodule

FILE: rtl/mm4_seq.sv
module mm4_seq
  import mm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [1:0]  column_index,
  input  logic [31:0] elem_row0,
  input  logic [31:0] elem_row1,
  input  logic [31:0] elem_row2,
  input  logic [31:0] elem_row3,
  input  logic        out_free,
  output lane_ctrl_t  ctrl,
  output logic [31:0] b_elem,
  output logic [1:0]  col,
  output logic        done
);

  seq_state_t  state, state_next;
  logic [1:0]  k, k_next;
  logic [31:0] b_col [4];
  logic        accept;

  assign accept = in_valid && !in_stall;
  assign b_elem = b_col[k];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
    end else begin
      state <= state_next;
      k <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_MUL) begin
      b_col[0] <= elem_row0;
      b_col[1] <= elem_row1;
      b_col[2] <= elem_row2;
      b_col[3] <= elem_row3;
      col <= column_index;
    end
  end

  always_comb begin
    state_next = state;
    k_next = k;
    in_stall = 1'b1;
    done = 1'b0;
    ctrl = '0;
    ctrl.k = k;
    ctrl.wr_col = column_index;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd == CMD_LOAD) begin
            ctrl.wr_en = 1'b1;
          end else begin
            state_next = ST_MUL_RAW;
            k_next = 2'd0;
          end
        end
      end
      ST_MUL_RAW: begin
        ctrl.mul_raw = 1'b1;
        state_next = ST_MUL_RND;
      end
      ST_MUL_RND: begin
        ctrl.mul_rnd = 1'b1;
        if (k == 2'd0) begin
          k_next = 2'd1;
          state_next = ST_MUL_RAW;
        end else begin
          state_next = ST_ADD_RAW;
        end
      end
      ST_ADD_RAW: begin
        ctrl.add_raw = 1'b1;
        state_next = ST_ADD_RND;
      end
      ST_ADD_RND: begin
        ctrl.add_rnd = 1'b1;
        if (k == 2'd3) begin
          state_next = ST_DONE;
        end else begin
          k_next = k + 2'd1;
          state_next = ST_MUL_RAW;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_MUL |=> state == ST_MUL_RAW && k == 2'd0)
    else $error("multiply item did not start at the first column");

  a_add_after_first: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD_RAW |-> k != 2'd0)
    else $error("add step with no second product");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_free |=> state == ST_DONE)
    else $error("result dropped while output busy");

endmodule

FILE: rtl/mm4_merge.sv
module mm4_merge
  import mm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        done,
  input  logic [1:0]  col,
  input  logic [31:0] lane_acc [NUM_ROWS],
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_column,
  output logic [31:0] prod_row0,
  output logic [31:0] prod_row1,
  output logic [31:0] prod_row2,
  output logic [31:0] prod_row3
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_column <= col;
      prod_row0 <= lane_acc[0];
      prod_row1 <= lane_acc[1];
      prod_row2 <= lane_acc[2];
      prod_row3 <= lane_acc[3];
    end
  end

endmodule

FILE: rtl/matrix_multiply_4x4.sv
// 4x4 single-precision matrix multiply, column-major. A load item (cmd 0) writes one
// column of the left matrix and gives no result. A multiply item (cmd 1) carries one
// right-matrix column and returns the product column: four row lanes each run one
// multiplier and one adder in turn, every operation taking a raw step and a rounding
// step (4 multiplies and 3 adds), then the result loads the merge register. A new item
// is taken once the lanes are free, even while a result still waits on a stalled output.
// Rounding is nearest even; subnormals are kept and every NaN comes out as the quiet
// NaN 0x7FC00000.
module matrix_multiply_4x4
  import mm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [1:0]  column_index,
  input  logic [31:0] elem_row0,
  input  logic [31:0] elem_row1,
  input  logic [31:0] elem_row2,
  input  logic [31:0] elem_row3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_column,
  output logic [31:0] prod_row0,
  output logic [31:0] prod_row1,
  output logic [31:0] prod_row2,
  output logic [31:0] prod_row3
);

  lane_ctrl_t  ctrl;
  logic [31:0] b_elem;
  logic [1:0]  col;
  logic        done;
  logic        out_free;
  logic [31:0] wr_data  [NUM_ROWS];
  logic [31:0] lane_acc [NUM_ROWS];

  assign wr_data[0] = elem_row0;
  assign wr_data[1] = elem_row1;
  assign wr_data[2] = elem_row2;
  assign wr_data[3] = elem_row3;

  mm4_seq u_seq (
    .clk, .rst, .in_valid, .in_stall, .cmd, .column_index,
    .elem_row0, .elem_row1, .elem_row2, .elem_row3,
    .out_free, .ctrl, .b_elem, .col, .done
  );

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    mm4_lane u_lane (
      .clk,
      .ctrl,
      .wr_data (wr_data[r]),
      .b_elem,
      .acc     (lane_acc[r])
    );
  end

  mm4_merge u_merge (
    .clk, .rst, .done, .col, .lane_acc, .out_free, .out_valid, .out_stall,
    .result_column, .prod_row0, .prod_row1, .prod_row2, .prod_row3
  );

endmodule
